>>> rtl/sald_pkg.sv
// ----------------------------------------------------------------------------
// sald_pkg
// Types and constants shared by the smoothed acceleration landing detector.
// ----------------------------------------------------------------------------
package sald_pkg;

	localparam int unsigned NUM_AXES    = 3;
	localparam int unsigned AXIS_W      = 2;
	localparam int unsigned SAMPLE_W    = 16;
	localparam int unsigned STATE_W     = 32;
	localparam int unsigned GAIN_W      = 16;
	localparam int unsigned THRESH_W    = 15;
	localparam int unsigned MAG_W       = 32;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned STEP_W      = 3;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_GAIN      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MOVING_THRESHOLD = 2'd1;

	localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd1014;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd768;

	// sequencer steps: filter multiplies run in steps 0..2, result in the last
	localparam logic [STEP_W-1:0] LAST_MUL_STEP = 3'd2;
	localparam logic [STEP_W-1:0] LAST_STEP     = 3'd5;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] accel_north;
		logic signed [SAMPLE_W-1:0] accel_east;
		logic signed [SAMPLE_W-1:0] accel_up;
	} in_t;

	typedef struct packed {
		logic             on_ground;
		logic [MAG_W-1:0] magnitude_squared;
	} out_t;

	typedef struct packed {
		logic              load;
		logic              mul_en;
		logic [AXIS_W-1:0] mul_axis;
		logic              finish;
	} cmd_t;

endpackage

>>> rtl/smoothed_accel_landing_detector.sv
// ----------------------------------------------------------------------------
// smoothed_accel_landing_detector
// Low-pass filtered acceleration magnitude with a landing threshold.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one north/east/up sample
// in q8.8 m/s^2; each request updates three first-order low-pass states and
// yields one result on out_valid/out_stall/out_data: on_ground and the sum of
// squares of the smoothed axes in q16.16.
// A request is taken when in_valid is high and in_stall low. in_stall is high
// while a request is being worked on. The sequencer runs one shared filter
// multiplier over the three axes in turn, then the squaring stage, and loads
// the result behind out_valid; a new request can be taken the cycle after the
// result is loaded, so a request is not taken before the last one is through.
// If out_stall holds a result, the next request is still accepted and worked
// on, and waits in its last step until the output register is taken.
// Reset (arst_n low) clears the filter states to zero, sets filter_gain to
// 1014 and moving_threshold to 768 and empties the output.
// Configuration: cfg_we with cfg_index 0 (filter_gain) or 1
// (moving_threshold); write only while no request is in flight.
// ----------------------------------------------------------------------------
module smoothed_accel_landing_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  sald_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output sald_pkg::out_t                    out_data,
	input  logic                              cfg_we,
	input  logic [sald_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sald_pkg::CFG_DATA_W-1:0]   cfg_data
);

	sald_pkg::cmd_t cmd;

	sald_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	sald_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule

>>> rtl/sald_dp.sv
// ----------------------------------------------------------------------------
// sald_dp
// Datapath: per-axis low-pass update, squaring, sum and threshold compare.
// ----------------------------------------------------------------------------
module sald_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sald_pkg::cmd_t                    cmd,
	input  sald_pkg::in_t                     in_data,
	input  logic                              cfg_we,
	input  logic [sald_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sald_pkg::CFG_DATA_W-1:0]   cfg_data,
	output sald_pkg::out_t                    out_data
);

	logic [sald_pkg::GAIN_W-1:0]   gain_q;
	logic [sald_pkg::THRESH_W-1:0] thr_q;
	logic [2*sald_pkg::THRESH_W-1:0] thr_sq_q;

	logic signed [sald_pkg::SAMPLE_W-1:0] sample_q [sald_pkg::NUM_AXES];
	logic signed [sald_pkg::STATE_W-1:0]  state_q  [sald_pkg::NUM_AXES];

	logic signed [sald_pkg::STATE_W:0]     diff;
	logic signed [sald_pkg::STATE_W+17:0]  prod;
	logic signed [sald_pkg::STATE_W:0]     delta_s1;
	logic signed [sald_pkg::STATE_W-1:0]   base_s1;
	logic [sald_pkg::AXIS_W-1:0]           ax_s1;
	logic                                  upd_v_s1;
	logic signed [sald_pkg::STATE_W:0]     upd_sum;
	logic signed [sald_pkg::STATE_W-1:0]   new_state;
	logic signed [sald_pkg::SAMPLE_W-1:0]  q88_s2;
	logic                                  sq_v_s2;
	logic signed [2*sald_pkg::SAMPLE_W-1:0] sq;
	logic [sald_pkg::MAG_W-1:0]            sum_q;
	sald_pkg::out_t                        out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= sald_pkg::GAIN_RESET;
			thr_q  <= sald_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			if (cfg_index == sald_pkg::REG_FILTER_GAIN) begin
				gain_q <= cfg_data[sald_pkg::GAIN_W-1:0];
			end
			if (cfg_index == sald_pkg::REG_MOVING_THRESHOLD) begin
				thr_q <= cfg_data[sald_pkg::THRESH_W-1:0];
			end
		end
	end

	// request capture and squared threshold
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q[0] <= in_data.accel_north;
			sample_q[1] <= in_data.accel_east;
			sample_q[2] <= in_data.accel_up;
			thr_sq_q    <= thr_q * thr_q;
		end
	end

	// filter multiply: (sample * 2^16 - state) * alpha, floor by 2^16
	assign diff = {sample_q[cmd.mul_axis][sald_pkg::SAMPLE_W-1], sample_q[cmd.mul_axis],
		16'h0000} - {state_q[cmd.mul_axis][sald_pkg::STATE_W-1], state_q[cmd.mul_axis]};
	assign prod = diff * $signed({1'b0, gain_q});

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			delta_s1 <= prod[sald_pkg::STATE_W+16:16];
			base_s1  <= state_q[cmd.mul_axis];
			ax_s1    <= cmd.mul_axis;
		end
	end

	assign upd_sum   = {base_s1[sald_pkg::STATE_W-1], base_s1} + delta_s1;
	assign new_state = upd_sum[sald_pkg::STATE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_v_s1 <= 1'b0;
			sq_v_s2  <= 1'b0;
			for (int i = 0; i < sald_pkg::NUM_AXES; i++) begin
				state_q[i] <= '0;
			end
		end else begin
			upd_v_s1 <= cmd.mul_en;
			sq_v_s2  <= upd_v_s1;
			if (upd_v_s1) begin
				state_q[ax_s1] <= new_state;
			end
		end
	end

	// smoothed axis in q8.8 is the top half of the state
	always_ff @(posedge clk) begin
		if (upd_v_s1) begin
			q88_s2 <= new_state[sald_pkg::STATE_W-1:16];
		end
	end

	assign sq = q88_s2 * q88_s2;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_q <= '0;
		end else if (sq_v_s2) begin
			sum_q <= sum_q + $unsigned(sq);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.on_ground         <= (sum_q < {2'b00, thr_sq_q});
			out_q.magnitude_squared <= sum_q;
		end
	end

	assign out_data = out_q;

endmodule

>>> rtl/sald_ctrl.sv
// ----------------------------------------------------------------------------
// sald_ctrl
// Sequencer: request handshake, step counter and output valid.
// ----------------------------------------------------------------------------
module sald_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output sald_pkg::cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                        state_q;
	logic [sald_pkg::STEP_W-1:0] step_q;
	logic                        out_valid_q;
	logic                        out_free;
	logic                        in_acc;
	logic                        at_last;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign at_last  = (state_q == ST_RUN) && (step_q == sald_pkg::LAST_STEP);

	always_comb begin
		cmd          = '0;
		cmd.load     = in_acc;
		cmd.mul_en   = (state_q == ST_RUN) && (step_q <= sald_pkg::LAST_MUL_STEP);
		cmd.mul_axis = step_q[sald_pkg::AXIS_W-1:0];
		cmd.finish   = at_last && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_acc) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// hold on the last step until the output register frees up
					if (cmd.finish) begin
						state_q <= ST_IDLE;
						step_q  <= '0;
					end else if (!at_last) begin
						step_q <= step_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					step_q  <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_accept_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_RUN) && (step_q == '0))
		else $error("accepted request did not start the sequence");

	a_finish_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (state_q == ST_RUN) && out_free)
		else $error("result loaded while output register busy or not running");

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("output valid raised without a finished request");

	a_no_mul_past_axes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_en |-> (step_q <= sald_pkg::LAST_MUL_STEP))
		else $error("filter multiply issued outside the axis steps");
`endif

endmodule
